// ----- rtl/core/fixed_point_line_intersection_macros.svh -----
// Assertion macros for the fixed-point line intersection block.
// They are used by the top level only. Synthesis sees empty bodies.
`ifndef FIXED_POINT_LINE_INTERSECTION_MACROS_SVH
`define FIXED_POINT_LINE_INTERSECTION_MACROS_SVH
`ifndef SYNTHESIS
`define FPLI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define FPLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define FPLI_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define FPLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/fpli_pkg.sv -----
// Shared constants, payload types and the saturation helper for the
// line intersection block. No dependencies.
package fpli_pkg;

   localparam int WORD_W        = 32;
   localparam int WIDE_W        = 64;
   localparam int FRAC_BITS_DEF = 12;
   localparam int COORD_BITS    = 32;
   // Saturation width is held between 16 and 32 bits.
   localparam int SAT_W = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 16) ? 16 : COORD_BITS);

   localparam logic signed [WIDE_W-1:0] SAT_MAX =
      $signed((64'd1 << (SAT_W - 1)) - 64'd1);
   localparam logic signed [WIDE_W-1:0] SAT_MIN = -SAT_MAX - 64'sd1;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      logic     first_vertical;
      word_type first_slope;
      word_type first_offset;
      logic     second_vertical;
      word_type second_slope;
      word_type second_offset;
   } req_type;

   // Travels beside the divider: everything needed after the quotient is known.
   typedef struct packed {
      logic     hit;
      logic     use_div;
      logic     neg;
      word_type x;
      word_type m;
      word_type n;
   } side_type;

   typedef struct packed {
      logic     intersects;
      word_type cross_x;
      word_type cross_y;
   } result_type;

   function automatic word_type sat_word(input logic signed [WIDE_W-1:0] v);
      word_type r;
      priority if (v > SAT_MAX) begin
         r = SAT_MAX[WORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[WORD_W-1:0];
      end else begin
         r = v[WORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/fpli_if.sv -----
// Valid/ready channel interfaces for line pairs and intersection results.
// Depends on fpli_pkg for the coordinate word type.
interface fpli_req_if;
   logic                first_vertical;
   fpli_pkg::word_type  first_slope;
   fpli_pkg::word_type  first_offset;
   logic                second_vertical;
   fpli_pkg::word_type  second_slope;
   fpli_pkg::word_type  second_offset;
   logic                valid;
   logic                ready;

   modport source (output valid, first_vertical, first_slope, first_offset,
                   second_vertical, second_slope, second_offset, input ready);
   modport sink   (input valid, first_vertical, first_slope, first_offset,
                   second_vertical, second_slope, second_offset, output ready);
endinterface

interface fpli_rsp_if;
   logic                intersects;
   fpli_pkg::word_type  cross_x;
   fpli_pkg::word_type  cross_y;
   logic                valid;
   logic                ready;

   modport source (output valid, intersects, cross_x, cross_y, input ready);
   modport sink   (input valid, intersects, cross_x, cross_y, output ready);
endinterface

// ----- rtl/core/fpli_prep.sv -----
// Front stage: classifies the line pair and sets up the divider operands.
// Depends on fpli_pkg.
module fpli_prep #(
   parameter int FRAC_BITS = fpli_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  fpli_pkg::req_type                               req_in,
   output logic                                            valid_ff,
   output logic [fpli_pkg::WORD_W+FRAC_BITS-1:0]           work_ff,
   output logic [fpli_pkg::WORD_W-1:0]                     den_ff,
   output fpli_pkg::side_type                              side_ff
);

   localparam int W  = fpli_pkg::WORD_W;
   localparam int WW = fpli_pkg::WIDE_W;
   localparam int NW = W + FRAC_BITS;

   fpli_pkg::word_type  lhs;
   logic signed [W:0]   num;
   logic signed [W:0]   den;
   logic [W:0]          num_abs;
   logic [W:0]          den_abs;
   logic                parallel;
   logic                flat_first;
   logic [NW-1:0]       work_in;
   logic [W-1:0]        den_in;
   fpli_pkg::side_type  side_in;

   always_comb begin
      parallel = (req_in.first_vertical & req_in.second_vertical) |
                 (~req_in.first_vertical & ~req_in.second_vertical &
                  (req_in.first_slope == req_in.second_slope));
      flat_first = ~req_in.first_vertical && (req_in.first_slope == '0);

      // A horizontal first line fixes y at its saturated intercept.
      lhs = flat_first ? fpli_pkg::sat_word(WW'(req_in.first_offset)) : req_in.first_offset;
      num = $signed({lhs[W-1], lhs}) -
            $signed({req_in.second_offset[W-1], req_in.second_offset});
      den = $signed({req_in.second_slope[W-1], req_in.second_slope}) -
            $signed({req_in.first_slope[W-1], req_in.first_slope});
      num_abs = num[W] ? -num : num;
      den_abs = den[W] ? -den : den;

      work_in = NW'(num_abs[W-1:0]) << FRAC_BITS;
      den_in  = den_abs[W-1:0];

      side_in.hit     = ~parallel;
      side_in.use_div = ~parallel & ~req_in.first_vertical & ~req_in.second_vertical;
      side_in.neg     = num[W] ^ den[W];
      side_in.x       = req_in.first_vertical ?
                        fpli_pkg::sat_word(WW'(req_in.first_offset)) :
                        fpli_pkg::sat_word(WW'(req_in.second_offset));
      side_in.m       = req_in.first_vertical ? req_in.second_slope : req_in.first_slope;
      side_in.n       = req_in.first_vertical ? req_in.second_offset : req_in.first_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         work_ff <= work_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

endmodule

// ----- rtl/core/fpli_div_cell.sv -----
// One cell of the divider chain: retires one quotient bit per beat and
// hands remainder, partial quotient and sideband to the next cell. Uses fpli_pkg.
module fpli_div_cell #(
   parameter int NW = fpli_pkg::WORD_W + fpli_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [fpli_pkg::WORD_W-1:0]   rem_i,
   input  logic [NW-1:0]                 work_i,
   input  logic [fpli_pkg::WORD_W-1:0]   den_i,
   input  fpli_pkg::side_type            side_i,
   output logic                          valid_ff,
   output logic [fpli_pkg::WORD_W-1:0]   rem_ff,
   output logic [NW-1:0]                 work_ff,
   output logic [fpli_pkg::WORD_W-1:0]   den_ff,
   output fpli_pkg::side_type            side_ff
);

   localparam int W = fpli_pkg::WORD_W;

   logic [W:0]    cand;
   logic [W:0]    diff;
   logic          ge;
   logic [W-1:0]  rem_in;
   logic [NW-1:0] work_in;

   // The next dividend bit shifts into the remainder; the quotient bit
   // shifts into the low end of the work word in its place.
   always_comb begin
      cand    = {rem_i, work_i[NW-1]};
      diff    = cand - {1'b0, den_i};
      ge      = cand >= {1'b0, den_i};
      rem_in  = ge ? diff[W-1:0] : cand[W-1:0];
      work_in = {work_i[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
         den_ff  <= den_i;
         side_ff <= side_i;
      end
   end

endmodule

// ----- rtl/core/fpli_eval.sv -----
// Back end: signs and saturates the quotient, then evaluates y on the
// chosen line over three registered stages. Depends on fpli_pkg.
module fpli_eval #(
   parameter int FRAC_BITS = fpli_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [fpli_pkg::WORD_W+FRAC_BITS-1:0]   quot_i,
   input  fpli_pkg::side_type                      side_i,
   output logic                                    valid_ff,
   output fpli_pkg::result_type                    res_ff
);

   localparam int W  = fpli_pkg::WORD_W;
   localparam int WW = fpli_pkg::WIDE_W;

   logic [WW-1:0]         q64;
   logic signed [WW-1:0]  qs;
   fpli_pkg::word_type    x1_in;
   logic signed [2*W-1:0] prod_in;
   logic signed [WW-1:0]  shifted;
   logic signed [WW-1:0]  sum;
   fpli_pkg::word_type    term;
   fpli_pkg::word_type    y_in;

   logic                  valid1_ff;
   logic                  valid2_ff;
   logic                  hit1_ff;
   logic                  hit2_ff;
   fpli_pkg::word_type    x1_ff;
   fpli_pkg::word_type    m1_ff;
   fpli_pkg::word_type    n1_ff;
   fpli_pkg::word_type    x2_ff;
   fpli_pkg::word_type    n2_ff;
   logic signed [2*W-1:0] prod2_ff;

   always_comb begin
      q64   = WW'(quot_i);
      qs    = side_i.neg ? -$signed(q64) : $signed(q64);
      x1_in = ~side_i.hit ? '0 :
              (side_i.use_div ? fpli_pkg::sat_word(qs) : side_i.x);

      prod_in = m1_ff * x1_ff;

      // Arithmetic shift floors toward minus infinity.
      shifted = WW'(prod2_ff) >>> FRAC_BITS;
      term    = fpli_pkg::sat_word(shifted);
      sum     = WW'(term) + WW'(n2_ff);
      y_in    = hit2_ff ? fpli_pkg::sat_word(sum) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid_ff  <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit1_ff  <= side_i.hit;
         x1_ff    <= x1_in;
         m1_ff    <= side_i.m;
         n1_ff    <= side_i.n;
         hit2_ff  <= hit1_ff;
         x2_ff    <= x1_ff;
         n2_ff    <= n1_ff;
         prod2_ff <= prod_in;
         res_ff.intersects <= hit2_ff;
         res_ff.cross_x    <= x2_ff;
         res_ff.cross_y    <= y_in;
      end
   end

endmodule

// ----- rtl/core/fixed_point_line_intersection.sv -----
// Fixed-point line intersection, top level: front stage, divider cell chain,
// evaluation stages and an output register with one skid entry.
// Throughput: one line pair per cycle while the skid entry is free; the chain of
// WORD_W + FRAC_BITS divider cells retires one quotient bit per cell, so every
// cell holds a different pair.
// Reset (synchronous, active high) clears all valid bits; the block is stateless.
`include "fixed_point_line_intersection_macros.svh"

module fixed_point_line_intersection #(
   parameter int FRAC_BITS = fpli_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   fpli_req_if.sink   req_chan,
   fpli_rsp_if.source rsp_chan
);

   localparam int W  = fpli_pkg::WORD_W;
   localparam int NW = W + FRAC_BITS;

   fpli_pkg::req_type    req_w;
   logic                 en;

   logic                 valid_c [0:NW];
   logic [W-1:0]         rem_c   [0:NW];
   logic [NW-1:0]        work_c  [0:NW];
   logic [W-1:0]         den_c   [0:NW];
   fpli_pkg::side_type   side_c  [0:NW];

   logic                 tail_valid;
   fpli_pkg::result_type tail_res;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   fpli_pkg::result_type rsp_ff;
   fpli_pkg::result_type skid_ff;
   logic                 out_free;
   logic                 load_out_skid;
   logic                 load_out_tail;
   logic                 load_skid;

   // The whole pipeline moves while the skid entry is free.
   assign en             = ~skid_valid_ff;
   assign req_chan.ready = en;

   assign req_w.first_vertical  = req_chan.first_vertical;
   assign req_w.first_slope     = req_chan.first_slope;
   assign req_w.first_offset    = req_chan.first_offset;
   assign req_w.second_vertical = req_chan.second_vertical;
   assign req_w.second_slope    = req_chan.second_slope;
   assign req_w.second_offset   = req_chan.second_offset;

   fpli_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .req_in   (req_w),
      .valid_ff (valid_c[0]),
      .work_ff  (work_c[0]),
      .den_ff   (den_c[0]),
      .side_ff  (side_c[0])
   );

   assign rem_c[0] = '0;

   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpli_div_cell #(.NW(NW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (valid_c[i]),
         .rem_i    (rem_c[i]),
         .work_i   (work_c[i]),
         .den_i    (den_c[i]),
         .side_i   (side_c[i]),
         .valid_ff (valid_c[i+1]),
         .rem_ff   (rem_c[i+1]),
         .work_ff  (work_c[i+1]),
         .den_ff   (den_c[i+1]),
         .side_ff  (side_c[i+1])
      );
   end

   fpli_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (valid_c[NW]),
      .quot_i   (work_c[NW]),
      .side_i   (side_c[NW]),
      .valid_ff (tail_valid),
      .res_ff   (tail_res)
   );

   always_comb begin
      out_free      = ~rsp_valid_ff | rsp_chan.ready;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out_skid = 1'b0;
      load_out_tail = 1'b0;
      load_skid     = 1'b0;
      priority if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
            load_out_skid = 1'b1;
         end
      end else if (tail_valid) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            load_out_tail = 1'b1;
         end else begin
            skid_valid_in = 1'b1;
            load_skid     = 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (load_out_skid) begin
         rsp_ff <= skid_ff;
      end else if (load_out_tail) begin
         rsp_ff <= tail_res;
      end
      if (load_skid) begin
         skid_ff <= tail_res;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.intersects = rsp_ff.intersects;
   assign rsp_chan.cross_x    = rsp_ff.cross_x;
   assign rsp_chan.cross_y    = rsp_ff.cross_y;

   `FPLI_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid entry holds a beat while the output register is empty")
   `FPLI_ASSERT_NEXT(a_skid_only_on_stall, clock, reset, !skid_valid_ff && out_free, !skid_valid_ff, "skid entry filled without a stall")
   `FPLI_ASSERT_NOW(a_parallel_zero, clock, reset, rsp_valid_ff && !rsp_ff.intersects, (rsp_ff.cross_x == '0) && (rsp_ff.cross_y == '0), "parallel result carries a nonzero point")

endmodule

// ----- verif/fixed_point_line_intersection_test.sv -----
`timescale 1ns / 100ps
// Self-checking regression for fixed_point_line_intersection: directed line pairs, then
// random pairs under several idle and stall mixes. Depends on fpli_pkg and fpli_if.
module fixed_point_line_intersection_test;

   localparam int                 FRAC_SHIFT     = 12;
   localparam int                 DRAIN_CYCLES   = 60;
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 PHASE_ITEMS    = 163;
   localparam longint             COORD_MAX      = 64'sd2147483647;
   localparam longint             COORD_MIN      = -64'sd2147483648;
   localparam fpli_pkg::word_type WMAX           = 32'sh7fffffff;
   localparam fpli_pkg::word_type WMIN           = 32'sh80000000;

   typedef enum int {
      BOTH_VERTICAL, SAME_SLOPE, LEVEL_VS_VERTICAL, LEVEL_VS_SLOPED,
      VERTICAL_VS_SLOPED, SLOPED_VS_VERTICAL, GENERAL, NOISE
   } pair_shape_type;

   typedef struct {
      fpli_pkg::req_type    pair;
      bit                   typed;
      fpli_pkg::result_type want;
   } stimulus_row_type;

   logic clock;
   logic reset;

   fpli_req_if req_chan ();
   fpli_rsp_if rsp_chan ();

   fixed_point_line_intersection dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fpli_pkg::result_type pending_crossings[$];
   stimulus_row_type     directed_rows[$];
   bit                   beat_typed;
   fpli_pkg::result_type beat_want;
   int                   sender_idle_pct;
   int                   receiver_stall_pct;
   int                   mismatch_count;
   int                   quiet_cycles;

   int sender_mix[4]   = '{0, 57, 0, 21};
   int receiver_mix[4] = '{0, 0, 57, 21};

   always #2 clock = ~clock;

   function automatic longint clamp_coord(input longint v);
      longint r;
      if (v > COORD_MAX) begin
         r = COORD_MAX;
      end else if (v < COORD_MIN) begin
         r = COORD_MIN;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // y on a sloped line; the shift of a negative product rounds down.
   function automatic longint height_at(input longint m, input longint n, input longint x);
      longint t;
      t = clamp_coord((m * x) >>> FRAC_SHIFT);
      return clamp_coord(t + n);
   endfunction

   function automatic longint scaled_quotient(input longint num, input longint den);
      longint s;
      s = num * (64'sd1 <<< FRAC_SHIFT);
      return clamp_coord(s / den);
   endfunction

   function automatic fpli_pkg::result_type predict_crossing(input fpli_pkg::req_type p);
      longint               m1, o1, m2, o2, x, y;
      fpli_pkg::result_type r;
      m1 = $signed(p.first_slope);
      o1 = $signed(p.first_offset);
      m2 = $signed(p.second_slope);
      o2 = $signed(p.second_offset);
      x = 0;
      y = 0;
      r.intersects = 1'b1;
      if (p.first_vertical && p.second_vertical) begin
         r.intersects = 1'b0;
      end else if (!p.first_vertical && !p.second_vertical && m1 == m2) begin
         r.intersects = 1'b0;
      end else if (!p.first_vertical && m1 == 0) begin
         y = clamp_coord(o1);
         if (p.second_vertical) begin
            x = clamp_coord(o2);
         end else begin
            x = scaled_quotient(y - o2, m2);
         end
      end else if (p.first_vertical) begin
         x = clamp_coord(o1);
         y = height_at(m2, o2, x);
      end else if (p.second_vertical) begin
         x = clamp_coord(o2);
         y = height_at(m1, o1, x);
      end else begin
         x = scaled_quotient(o1 - o2, m2 - m1);
         y = height_at(m1, o1, x);
      end
      r.cross_x = x[fpli_pkg::WORD_W-1:0];
      r.cross_y = y[fpli_pkg::WORD_W-1:0];
      return r;
   endfunction

   function automatic stimulus_row_type line_row(
      input bit v1, input fpli_pkg::word_type m1, input fpli_pkg::word_type o1,
      input bit v2, input fpli_pkg::word_type m2, input fpli_pkg::word_type o2,
      input bit typed, input bit hit,
      input fpli_pkg::word_type x, input fpli_pkg::word_type y);
      stimulus_row_type r;
      r.pair.first_vertical  = v1;
      r.pair.first_slope     = m1;
      r.pair.first_offset    = o1;
      r.pair.second_vertical = v2;
      r.pair.second_slope    = m2;
      r.pair.second_offset   = o2;
      r.typed                = typed;
      r.want.intersects      = hit;
      r.want.cross_x         = x;
      r.want.cross_y         = y;
      return r;
   endfunction

   function automatic fpli_pkg::word_type pick_word();
      fpli_pkg::word_type w;
      case ($urandom_range(0, 6))
         0: begin
            w = $urandom_range(0, 400) - 200;
         end
         1: begin
            case ($urandom_range(0, 4))
               0: w = WMAX;
               1: w = WMIN;
               2: w = 0;
               3: w = -1;
               default: w = 1;
            endcase
         end
         2: begin
            w = ($urandom_range(0, 64) - 32) * 4096;
         end
         default: begin
            w = $urandom;
         end
      endcase
      return w;
   endfunction

   function automatic fpli_pkg::req_type pick_pair();
      fpli_pkg::req_type p;
      pair_shape_type    shape;
      p.first_vertical  = 1'($urandom_range(0, 1));
      p.first_slope     = pick_word();
      p.first_offset    = pick_word();
      p.second_vertical = 1'($urandom_range(0, 1));
      p.second_slope    = pick_word();
      p.second_offset   = pick_word();
      shape = pair_shape_type'($urandom_range(BOTH_VERTICAL, NOISE));
      if ($urandom_range(0, 2) == 0) begin
         shape = GENERAL;
      end
      case (shape)
         BOTH_VERTICAL: begin
            p.first_vertical  = 1'b1;
            p.second_vertical = 1'b1;
         end
         SAME_SLOPE: begin
            p.first_vertical  = 1'b0;
            p.second_vertical = 1'b0;
            p.second_slope    = p.first_slope;
         end
         LEVEL_VS_VERTICAL: begin
            p.first_vertical  = 1'b0;
            p.first_slope     = 0;
            p.second_vertical = 1'b1;
         end
         LEVEL_VS_SLOPED: begin
            p.first_vertical  = 1'b0;
            p.first_slope     = 0;
            p.second_vertical = 1'b0;
         end
         VERTICAL_VS_SLOPED: begin
            p.first_vertical  = 1'b1;
            p.second_vertical = 1'b0;
         end
         SLOPED_VS_VERTICAL: begin
            p.first_vertical  = 1'b0;
            p.second_vertical = 1'b1;
         end
         GENERAL: begin
            p.first_vertical  = 1'b0;
            p.second_vertical = 1'b0;
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // Drive one line pair at the falling edge and hold it until the block takes it.
   task automatic send_pair(input fpli_pkg::req_type p, input bit typed,
                            input fpli_pkg::result_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.first_vertical  <= p.first_vertical;
      req_chan.first_slope     <= p.first_slope;
      req_chan.first_offset    <= p.first_offset;
      req_chan.second_vertical <= p.second_vertical;
      req_chan.second_slope    <= p.second_slope;
      req_chan.second_offset   <= p.second_offset;
      beat_typed               <= typed;
      beat_want                <= want;
      req_chan.valid           <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_crossings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      fpli_pkg::req_type    seen_pair;
      fpli_pkg::result_type want;
      bit                   moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            seen_pair.first_vertical  = req_chan.first_vertical;
            seen_pair.first_slope     = req_chan.first_slope;
            seen_pair.first_offset    = req_chan.first_offset;
            seen_pair.second_vertical = req_chan.second_vertical;
            seen_pair.second_slope    = req_chan.second_slope;
            seen_pair.second_offset   = req_chan.second_offset;
            if (beat_typed) begin
               pending_crossings.push_back(beat_want);
            end else begin
               pending_crossings.push_back(predict_crossing(seen_pair));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (pending_crossings.size() == 0) begin
               $error("unexpected result beat: intersects %0b x %0d y %0d",
                      rsp_chan.intersects, rsp_chan.cross_x, rsp_chan.cross_y);
               mismatch_count++;
            end else begin
               want = pending_crossings.pop_front();
               if (rsp_chan.intersects !== want.intersects) begin
                  $error("intersects: expected %0b, got %0b", want.intersects,
                         rsp_chan.intersects);
                  mismatch_count++;
               end
               if (rsp_chan.cross_x !== want.cross_x) begin
                  $error("cross_x: expected %0d, got %0d", want.cross_x, rsp_chan.cross_x);
                  mismatch_count++;
               end
               if (rsp_chan.cross_y !== want.cross_y) begin
                  $error("cross_y: expected %0d, got %0d", want.cross_y, rsp_chan.cross_y);
                  mismatch_count++;
               end
            end
         end
      end
      if (moved) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("fixed_point_line_intersection regression: fail");
         $finish;
      end
   end

   initial begin
      fpli_pkg::result_type none;
      clock                    = 1'b0;
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.first_vertical  = 1'b0;
      req_chan.first_slope     = '0;
      req_chan.first_offset    = '0;
      req_chan.second_vertical = 1'b0;
      req_chan.second_slope    = '0;
      req_chan.second_offset   = '0;
      rsp_chan.ready           = 1'b0;
      beat_typed               = 1'b0;
      beat_want                = '0;
      sender_idle_pct          = 0;
      receiver_stall_pct       = 0;
      mismatch_count           = 0;
      quiet_cycles             = 0;
      none                     = '0;

      // Parallel cases, both vertical and equal slopes.
      directed_rows.push_back(line_row(1, 0, 5, 1, 0, 7, 1, 0, 0, 0));
      directed_rows.push_back(line_row(1, WMIN, WMAX, 1, WMAX, WMIN, 1, 0, 0, 0));
      directed_rows.push_back(line_row(0, 4096, 3, 0, 4096, 9, 1, 0, 0, 0));
      directed_rows.push_back(line_row(0, WMIN, WMAX, 0, WMIN, WMIN, 1, 0, 0, 0));
      directed_rows.push_back(line_row(0, 0, -1, 0, 0, 1, 1, 0, 0, 0));
      // Horizontal first line against vertical and sloped targets.
      directed_rows.push_back(line_row(0, 0, -100, 1, 777, 250, 1, 1, 250, -100));
      directed_rows.push_back(line_row(0, 0, WMIN, 1, 0, WMAX, 1, 1, WMAX, WMIN));
      directed_rows.push_back(line_row(0, 0, 10, 0, 4096, 2, 1, 1, 8, 10));
      directed_rows.push_back(line_row(0, 0, WMAX, 0, 1, WMIN, 1, 1, WMAX, WMAX));
      directed_rows.push_back(line_row(0, 0, WMAX, 0, -1, WMIN, 1, 1, WMIN, WMAX));
      directed_rows.push_back(line_row(0, 0, -3, 0, WMIN, WMAX, 0, 0, 0, 0));
      // Vertical first line; its slope field must be ignored.
      directed_rows.push_back(line_row(1, 0, 8, 0, 8192, 1, 1, 1, 8, 17));
      directed_rows.push_back(line_row(1, -5, WMAX, 0, WMAX, WMAX, 1, 1, WMAX, WMAX));
      directed_rows.push_back(line_row(1, 77, WMIN, 0, WMAX, WMIN, 1, 1, WMIN, WMIN));
      directed_rows.push_back(line_row(1, 0, -1, 0, 1, 0, 1, 1, -1, -1));
      directed_rows.push_back(line_row(1, 0, 3, 0, 4096, 0, 1, 1, 3, 3));
      // Sloped first line against a vertical target.
      directed_rows.push_back(line_row(0, 8192, 5, 1, 0, 10, 1, 1, 10, 25));
      directed_rows.push_back(line_row(0, 12345, -40, 1, 12345, WMIN, 0, 0, 0, 0));
      // General case, with truncation of a negative quotient and a unit divisor.
      directed_rows.push_back(line_row(0, 4096, 0, 0, -4096, 10, 1, 1, 5, 5));
      directed_rows.push_back(line_row(0, 4096, 0, 0, 12288, 7, 1, 1, -3, -3));
      directed_rows.push_back(line_row(0, 1, 1, 0, 2, 0, 1, 1, 4096, 2));
      directed_rows.push_back(line_row(0, WMIN, WMAX, 0, WMAX, WMIN, 0, 0, 0, 0));
      directed_rows.push_back(line_row(0, WMAX, WMIN, 0, 32'sh7ffffffe, WMAX, 0, 0, 0, 0));
      directed_rows.push_back(line_row(0, -1, 0, 0, 1, -1, 0, 0, 0, 0));
      directed_rows.push_back(line_row(0, 3, -7, 0, -5, 11, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].want);
      end
      wait_for_drain();

      // Each phase starts from an empty pipeline, so the sender pauses for a full drain.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_mix[phase];
         receiver_stall_pct = receiver_mix[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_pair(pick_pair(), 1'b0, none);
         end
         wait_for_drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("fixed_point_line_intersection regression: pass");
      end else begin
         $display("fixed_point_line_intersection regression: fail");
      end
      $finish;
   end

endmodule
